/* src/swa_pkg.sv */
// Shared constants, status codes and controller/datapath link types for the airtime limiter.
package swa_pkg;

	localparam int unsigned NUM_BUCKETS = 64;
	localparam int unsigned SLOT_MS     = 1000;
	localparam int unsigned WINDOW_US   = 32'd64000000;

	localparam int unsigned TIME_W   = 48;
	localparam int unsigned COST_W   = 32;
	localparam int unsigned TOTAL_W  = 40;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned WAIT_W   = 16;

	localparam int unsigned IDX_W     = $clog2(NUM_BUCKETS);
	localparam int unsigned CNT_W     = $clog2(NUM_BUCKETS + 2);
	localparam int unsigned REM_W     = $clog2(SLOT_MS + 1);
	localparam int unsigned KMS_W     = $clog2(NUM_BUCKETS * SLOT_MS + 1);

	// Slot divider: the timestamp is split into 16-bit digits, each divided by the slot
	// length through a reciprocal multiply, exact for partial remainders below SLOT_MS * 2^16.
	localparam int unsigned DIG_W       = 16;
	localparam int unsigned NUM_DIGITS  = TIME_W / DIG_W;
	localparam int unsigned PART_W      = REM_W + DIG_W;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam longint unsigned RECIP   =
		((64'd1 << RECIP_SHIFT) + 64'(SLOT_MS) - 64'd1) / 64'(SLOT_MS);
	localparam int unsigned RECIP_W     = $clog2(RECIP + 1);
	localparam int unsigned PROD_W      = PART_W + RECIP_W;
	localparam int unsigned DIV_CNT_W   = $clog2(NUM_DIGITS + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_ADMIT     = 3'd0,
		ST_INVALID   = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_RETRY     = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic epoch;
		logic walk;
		logic search_start;
		logic adm_rd;
		logic adm_wr;
	} dp_cmd_t;

	typedef struct packed {
		logic invalid;
		logic too_large;
		logic div_busy;
		logic restart;
		logic far;
		logic fits;
		logic walk_done;
		logic found;
	} dp_stat_t;

endpackage

/* src/sliding_window_airtime_admission.sv */
// Top level of the sliding-window airtime admission block: controller, datapath, result register.
// An invalid or too-large word goes straight to the result. Any other word waits on the slot
// divider, expires the slots passed since the epoch (none on restart or a jump of a ring or
// more), then is admitted or searches ahead: to the freeing slot on retry, all 64 on overflow.
// One word in flight; the next is taken as its result appears.
// Reset clears the budget, bucket valid bits, window total, epoch and started flag at once.
module sliding_window_airtime_admission (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [swa_pkg::COST_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [swa_pkg::TIME_W-1:0]    time_now_ms,
	input  logic [swa_pkg::COST_W-1:0]    request_cost_us,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [swa_pkg::STATUS_W-1:0]  status,
	output logic [swa_pkg::WAIT_W-1:0]    wait_time_ms
);

	swa_pkg::dp_cmd_t  cmd;
	swa_pkg::dp_stat_t stat;
	swa_pkg::status_t  res_code;
	logic              emit;
	logic              out_free;
	logic [swa_pkg::WAIT_W-1:0] dp_wait;

	logic                         out_valid_q;
	logic [swa_pkg::STATUS_W-1:0] status_q;
	logic [swa_pkg::WAIT_W-1:0]   wait_q;

	// The output register frees up when its word is taken, so a finished
	// result can be handed over in the same cycle the previous one leaves.
	assign out_free = !out_valid_q || !out_stall;

	swa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_free (out_free),
		.emit     (emit),
		.res_code (res_code),
		.cmd      (cmd),
		.stat     (stat)
	);

	swa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.time_now_ms     (time_now_ms),
		.request_cost_us (request_cost_us),
		.cmd             (cmd),
		.stat            (stat),
		.wait_time       (dp_wait)
	);

	// Hold the result word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The wait is only meaningful for a retry; zero it otherwise.
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= res_code;
			wait_q   <= (res_code == swa_pkg::ST_RETRY) ? dp_wait : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign wait_time_ms = wait_q;

endmodule

/* src/swa_div.sv */
// Slot divider: timestamp by slot length, one 16-bit digit at a time by reciprocal multiply.
module swa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [swa_pkg::TIME_W-1:0]  dividend,
	output logic                        busy,
	output logic [swa_pkg::TIME_W-1:0]  quot,
	output logic [swa_pkg::REM_W-1:0]   rem,
	output logic [swa_pkg::IDX_W-1:0]   idx
);

	logic [swa_pkg::TIME_W-1:0]    num_q;
	logic [swa_pkg::TIME_W-1:0]    quot_q;
	logic [swa_pkg::REM_W-1:0]     rem_q;
	logic [swa_pkg::DIG_W-1:0]     qdig_q;
	logic [swa_pkg::DIV_CNT_W-1:0] steps_q;
	logic                          phase_q;
	logic                          busy_q;

	logic [swa_pkg::PART_W-1:0] part;
	logic [swa_pkg::PROD_W-1:0] prod;
	logic [swa_pkg::DIG_W-1:0]  qdig;
	logic [swa_pkg::PART_W-1:0] back;
	logic [swa_pkg::REM_W-1:0]  rem_nx;

	always_comb begin
		part   = {rem_q, num_q[swa_pkg::TIME_W-1 -: swa_pkg::DIG_W]};
		// first phase of a digit: quotient digit from the reciprocal
		prod   = swa_pkg::PROD_W'(part) * swa_pkg::PROD_W'(swa_pkg::RECIP);
		qdig   = prod[swa_pkg::RECIP_SHIFT +: swa_pkg::DIG_W];
		// second phase: remainder carried into the next digit
		back   = swa_pkg::PART_W'(qdig_q) * swa_pkg::PART_W'(swa_pkg::SLOT_MS);
		rem_nx = swa_pkg::REM_W'(part - back);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
			phase_q <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			steps_q <= swa_pkg::DIV_CNT_W'(swa_pkg::NUM_DIGITS);
			phase_q <= 1'b0;
		end else if (busy_q) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				busy_q  <= steps_q != swa_pkg::DIV_CNT_W'(1);
				steps_q <= steps_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			quot_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				qdig_q <= qdig;
			end else begin
				num_q  <= {num_q[swa_pkg::TIME_W-swa_pkg::DIG_W-1:0], {swa_pkg::DIG_W{1'b0}}};
				quot_q <= {quot_q[swa_pkg::TIME_W-swa_pkg::DIG_W-1:0], qdig_q};
				rem_q  <= rem_nx;
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;
	// the ring size is a power of two, so the low quotient bits pick the bucket
	assign idx  = quot_q[swa_pkg::IDX_W-1:0];

endmodule

/* src/swa_dp.sv */
// Datapath: budget register, bucket memory, window total, expiry and wait-search walk.
module swa_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [swa_pkg::COST_W-1:0]   cfg_wr_data,
	input  logic [swa_pkg::TIME_W-1:0]   time_now_ms,
	input  logic [swa_pkg::COST_W-1:0]   request_cost_us,
	input  swa_pkg::dp_cmd_t             cmd,
	output swa_pkg::dp_stat_t            stat,
	output logic [swa_pkg::WAIT_W-1:0]   wait_time
);

	logic [swa_pkg::COST_W-1:0]  budget_q;
	logic [swa_pkg::TIME_W-1:0]  now_q;
	logic [swa_pkg::COST_W-1:0]  cost_q;
	logic [swa_pkg::TIME_W-1:0]  epoch_q;
	logic [swa_pkg::IDX_W-1:0]   epoch_idx_q;
	logic                        started_q;
	logic [swa_pkg::TOTAL_W-1:0] total_q;
	logic [swa_pkg::NUM_BUCKETS-1:0] valid_q;

	logic [swa_pkg::COST_W-1:0]  mem [swa_pkg::NUM_BUCKETS];
	logic [swa_pkg::COST_W-1:0]  bkt_data_s1;
	logic                        bkt_vld_s1;
	logic                        walk_pend_s1;

	logic [swa_pkg::IDX_W-1:0]   ptr_q;
	logic [swa_pkg::CNT_W-1:0]   cnt_q;
	logic [swa_pkg::CNT_W-1:0]   limit_q;
	logic                        walk_expire_q;
	logic [swa_pkg::TOTAL_W-1:0] left_q;
	logic                        neg_q;
	logic                        found_q;
	logic [swa_pkg::KMS_W-1:0]   kms_q;
	logic [swa_pkg::WAIT_W-1:0]  wait_q;

	logic                        div_busy;
	logic [swa_pkg::TIME_W-1:0]  slot;
	logic [swa_pkg::REM_W-1:0]   slot_rem;
	logic [swa_pkg::IDX_W-1:0]   slot_idx;

	logic [swa_pkg::COST_W-1:0]  bucket_val;
	logic [swa_pkg::COST_W-1:0]  room;
	logic [swa_pkg::TIME_W-1:0]  gap;
	logic                        walk_issue;
	logic                        rd_en;
	logic [swa_pkg::IDX_W-1:0]   rd_addr;
	logic [swa_pkg::TOTAL_W-1:0] left_diff;
	logic                        left_borrow;
	logic [swa_pkg::KMS_W-1:0]   wait_raw;
	logic [swa_pkg::WAIT_W-1:0]  wait_sat;

	function automatic logic [swa_pkg::IDX_W-1:0] idx_inc(input logic [swa_pkg::IDX_W-1:0] i);
		return (i == swa_pkg::IDX_W'(swa_pkg::NUM_BUCKETS - 1)) ? '0 : i + 1'b1;
	endfunction

	swa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (now_q),
		.busy     (div_busy),
		.quot     (slot),
		.rem      (slot_rem),
		.idx      (slot_idx)
	);

	always_comb begin
		bucket_val = bkt_vld_s1 ? bkt_data_s1 : '0;
		room       = budget_q - cost_q;
		gap        = slot - epoch_q;
		walk_issue = cmd.walk && (cnt_q <= limit_q);
		rd_en      = cmd.adm_rd || walk_issue;
		rd_addr    = cmd.adm_rd ? slot_idx : ptr_q;
		{left_borrow, left_diff} = {1'b0, left_q} - {1'b0, swa_pkg::TOTAL_W'(bucket_val)};
		wait_raw   = kms_q - swa_pkg::KMS_W'(slot_rem);
		if (32'(wait_raw) > 32'hFFFF) begin
			wait_sat = '1;
		end else begin
			wait_sat = swa_pkg::WAIT_W'(wait_raw);
		end

		stat.invalid   = (budget_q == '0) || (cost_q == '0) ||
		                 (budget_q > swa_pkg::COST_W'(swa_pkg::WINDOW_US));
		stat.too_large = cost_q > budget_q;
		stat.div_busy  = div_busy;
		stat.restart   = !started_q || (slot < epoch_q);
		stat.far       = gap >= swa_pkg::TIME_W'(swa_pkg::NUM_BUCKETS);
		stat.fits      = total_q <= swa_pkg::TOTAL_W'(room);
		stat.walk_done = (cnt_q > limit_q) && !walk_pend_s1;
		stat.found     = found_q;
	end

	// bucket memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.adm_wr) begin
			mem[slot_idx] <= bucket_val + cost_q;
		end
		if (rd_en) begin
			bkt_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q  <= time_now_ms;
			cost_q <= request_cost_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q      <= '0;
			epoch_q       <= '0;
			epoch_idx_q   <= '0;
			started_q     <= 1'b0;
			total_q       <= '0;
			valid_q       <= '0;
			bkt_vld_s1    <= 1'b0;
			walk_pend_s1  <= 1'b0;
			ptr_q         <= '0;
			cnt_q         <= '0;
			limit_q       <= '0;
			walk_expire_q <= 1'b0;
			left_q        <= '0;
			neg_q         <= 1'b0;
			found_q       <= 1'b0;
			kms_q         <= '0;
			wait_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				budget_q <= cfg_wr_data;
			end
			if (rd_en) begin
				bkt_vld_s1 <= valid_q[rd_addr];
			end
			walk_pend_s1 <= walk_issue;

			// issue side: advance the pointer, drop expired buckets
			if (walk_issue) begin
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= idx_inc(ptr_q);
				if (walk_expire_q) begin
					valid_q[ptr_q] <= 1'b0;
				end
			end

			// process side: the bucket whose read was issued the cycle before
			if (walk_pend_s1) begin
				if (walk_expire_q) begin
					total_q <= total_q - swa_pkg::TOTAL_W'(bucket_val);
				end else begin
					left_q <= left_diff;
					neg_q  <= neg_q | left_borrow;
					kms_q  <= kms_q + swa_pkg::KMS_W'(swa_pkg::SLOT_MS);
					if (!found_q && !neg_q && !left_borrow &&
					    left_diff <= swa_pkg::TOTAL_W'(room)) begin
						found_q <= 1'b1;
						wait_q  <= wait_sat;
					end
				end
			end

			if (cmd.epoch) begin
				epoch_q     <= slot;
				epoch_idx_q <= slot_idx;
				started_q   <= 1'b1;
				if (stat.restart || stat.far) begin
					valid_q <= '0;
					total_q <= '0;
				end else begin
					ptr_q         <= idx_inc(epoch_idx_q);
					cnt_q         <= swa_pkg::CNT_W'(1);
					limit_q       <= swa_pkg::CNT_W'(gap);
					walk_expire_q <= 1'b1;
				end
			end

			if (cmd.search_start) begin
				ptr_q         <= idx_inc(slot_idx);
				cnt_q         <= swa_pkg::CNT_W'(1);
				limit_q       <= swa_pkg::CNT_W'(swa_pkg::NUM_BUCKETS);
				walk_expire_q <= 1'b0;
				left_q        <= total_q;
				neg_q         <= 1'b0;
				found_q       <= 1'b0;
				kms_q         <= swa_pkg::KMS_W'(swa_pkg::SLOT_MS);
			end

			if (cmd.adm_wr) begin
				valid_q[slot_idx] <= 1'b1;
				total_q           <= total_q + swa_pkg::TOTAL_W'(cost_q);
			end
		end
	end

	assign wait_time = wait_q;

	a_ring_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.epoch && (stat.restart || stat.far) |=> total_q == '0 && valid_q == '0)
		else $error("ring not cleared after restart or large time jump");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= limit_q + 1'b1)
		else $error("walk issued past its limit");

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !cmd.search_start |=> found_q)
		else $error("wait search result lost before a new search");

endmodule

/* src/swa_ctrl.sv */
// Controller state machine: sequences check, divide, expiry, admit and wait search.
module swa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               out_free,
	output logic               emit,
	output swa_pkg::status_t   res_code,
	output swa_pkg::dp_cmd_t   cmd,
	input  swa_pkg::dp_stat_t  stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIVIDE,
		S_EPOCH,
		S_EXPIRE,
		S_ROOM,
		S_ADM_RD,
		S_ADM_WR,
		S_SEARCH,
		S_FINISH
	} state_t;

	state_t           state_q;
	swa_pkg::status_t res_code_q;

	always_comb begin
		in_stall         = state_q != S_IDLE;
		emit             = (state_q == S_FINISH) && out_free;
		cmd.load         = (state_q == S_IDLE) && in_valid;
		cmd.div_start    = (state_q == S_CHECK) && !stat.invalid && !stat.too_large;
		cmd.epoch        = state_q == S_EPOCH;
		cmd.walk         = (state_q == S_EXPIRE) || (state_q == S_SEARCH);
		cmd.search_start = (state_q == S_ROOM) && !stat.fits;
		cmd.adm_rd       = state_q == S_ADM_RD;
		cmd.adm_wr       = state_q == S_ADM_WR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_code_q <= swa_pkg::ST_ADMIT;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stat.invalid) begin
						res_code_q <= swa_pkg::ST_INVALID;
						state_q    <= S_FINISH;
					end else if (stat.too_large) begin
						res_code_q <= swa_pkg::ST_TOO_LARGE;
						state_q    <= S_FINISH;
					end else begin
						state_q <= S_DIVIDE;
					end
				end
				S_DIVIDE: begin
					if (!stat.div_busy) state_q <= S_EPOCH;
				end
				S_EPOCH: begin
					if (stat.restart || stat.far) state_q <= S_ROOM;
					else state_q <= S_EXPIRE;
				end
				S_EXPIRE: begin
					if (stat.walk_done) state_q <= S_ROOM;
				end
				S_ROOM: begin
					if (stat.fits) state_q <= S_ADM_RD;
					else state_q <= S_SEARCH;
				end
				S_ADM_RD: begin
					state_q <= S_ADM_WR;
				end
				S_ADM_WR: begin
					res_code_q <= swa_pkg::ST_ADMIT;
					state_q    <= S_FINISH;
				end
				S_SEARCH: begin
					if (stat.found) begin
						res_code_q <= swa_pkg::ST_RETRY;
						state_q    <= S_FINISH;
					end else if (stat.walk_done) begin
						res_code_q <= swa_pkg::ST_OVERFLOW;
						state_q    <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_code = res_code_q;

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_CHECK)
		else $error("accepted word not taken into check");

	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> state_q == S_IDLE)
		else $error("controller did not return to idle after handing over a result");

	a_found_retry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH && stat.found |=>
		state_q == S_FINISH && res_code_q == swa_pkg::ST_RETRY)
		else $error("wait search hit not reported as retry");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the sliding-window airtime admission block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no word moving on either side before the run is abandoned, well above what the
	// slowest word and the long receiver hold-off need.
	localparam int unsigned QUIET_LIMIT = 4000;
	// Cycles of hold-off once enough results have come, to fill the block and stall its input.
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned HOLD_AFTER  = 150;
	// Settling time at the end, above the worst-case latency of one word.
	localparam int unsigned DRAIN_CYCLES = 200;

	typedef struct {
		logic [swa_pkg::TIME_W-1:0] t;
		logic [swa_pkg::COST_W-1:0] c;
	} req_t;

	typedef struct {
		swa_pkg::status_t           st;
		logic [swa_pkg::WAIT_W-1:0] wt;
	} verdict_t;

	logic                         clk             = 1'b0;
	logic                         arst_n          = 1'b0;
	logic                         cfg_wr_en       = 1'b0;
	logic [swa_pkg::COST_W-1:0]   cfg_wr_data     = '0;
	logic                         in_valid        = 1'b0;
	logic                         in_stall;
	logic [swa_pkg::TIME_W-1:0]   time_now_ms     = '0;
	logic [swa_pkg::COST_W-1:0]   request_cost_us = '0;
	logic                         out_valid;
	logic                         out_stall       = 1'b0;
	logic [swa_pkg::STATUS_W-1:0] status;
	logic [swa_pkg::WAIT_W-1:0]   wait_time_ms;

	// Stimulus and expectations.
	req_t        pending_reqs[$];
	verdict_t    due_verdicts[$];
	int unsigned idle_pct   = 32;
	int unsigned mismatches = 0;
	int unsigned got_cnt    = 0;
	int unsigned quiet_cnt  = 0;
	int unsigned hold_left  = 0;
	bit          hold_done  = 1'b0;
	logic [swa_pkg::TIME_W-1:0] t_cursor = '0;

	// Own copy of the limiter state and its one register.
	bit [swa_pkg::COST_W-1:0]  budget_mirror = '0;
	bit [swa_pkg::COST_W-1:0]  bucket_us[swa_pkg::NUM_BUCKETS];
	bit [swa_pkg::TOTAL_W-1:0] window_total  = '0;
	bit [swa_pkg::TIME_W-1:0]  epoch_mirror  = '0;
	bit                        started       = 1'b0;

	sliding_window_airtime_admission u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.time_now_ms     (time_now_ms),
		.request_cost_us (request_cost_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.wait_time_ms    (wait_time_ms)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_ring();
		foreach (bucket_us[i])
			bucket_us[i] = '0;
		window_total = '0;
	endfunction

	// Work out the verdict on one request and advance the window state as the block does.
	function automatic verdict_t admission_verdict(input bit [swa_pkg::TIME_W-1:0] now,
			input bit [swa_pkg::COST_W-1:0] cost);
		verdict_t    v;
		bit [swa_pkg::TIME_W-1:0] slot, gap;
		bit [63:0]   room, left;
		int unsigned rem, idx, w;
		v.st = swa_pkg::ST_ADMIT;
		v.wt = '0;
		if (budget_mirror == 0 || cost == 0 || budget_mirror > swa_pkg::WINDOW_US) begin
			v.st = swa_pkg::ST_INVALID;
			return v;
		end
		if (cost > budget_mirror) begin
			v.st = swa_pkg::ST_TOO_LARGE;
			return v;
		end
		slot = now / swa_pkg::SLOT_MS;
		rem  = 32'(now % swa_pkg::SLOT_MS);
		// Restart the window on the first request or when time runs backwards.
		if (!started || slot < epoch_mirror) begin
			clear_ring();
			started = 1'b1;
		end else begin
			gap = slot - epoch_mirror;
			if (gap >= swa_pkg::NUM_BUCKETS) begin
				clear_ring();
			end else begin
				for (int k = 1; k <= gap; k++) begin
					idx = 32'((epoch_mirror + k) % swa_pkg::NUM_BUCKETS);
					window_total = window_total - bucket_us[idx];
					bucket_us[idx] = '0;
				end
			end
		end
		epoch_mirror = slot;
		room = 64'(budget_mirror) - 64'(cost);
		if (window_total <= room) begin
			idx = 32'(slot % swa_pkg::NUM_BUCKETS);
			bucket_us[idx] = bucket_us[idx] + cost;
			window_total = window_total + cost;
			return v;
		end
		// Find the first future slot whose expiry frees enough airtime.
		left = 64'(window_total);
		for (int k = 1; k <= swa_pkg::NUM_BUCKETS; k++) begin
			idx = 32'((slot + k) % swa_pkg::NUM_BUCKETS);
			left = left - bucket_us[idx];
			if (left <= room) begin
				w = k * swa_pkg::SLOT_MS - rem;
				v.st = swa_pkg::ST_RETRY;
				v.wt = (w > 32'hFFFF) ? 16'hFFFF : w[swa_pkg::WAIT_W-1:0];
				return v;
			end
		end
		v.st = swa_pkg::ST_OVERFLOW;
		return v;
	endfunction

	// Driver: predict each accepted word, then offer the next one or idle.
	always @(posedge clk) begin
		req_t r;
		if (in_valid && !in_stall)
			due_verdicts.push_back(admission_verdict(time_now_ms, request_cost_us));
		// Hold the payload while stalled; only a free channel may change.
		if (!in_valid || !in_stall) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				r = pending_reqs.pop_front();
				in_valid        <= 1'b1;
				time_now_ms     <= r.t;
				request_cost_us <= r.c;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each accepted result against the oldest expectation, then decide the stall.
	always @(posedge clk) begin
		verdict_t v;
		if (out_valid && !out_stall) begin
			got_cnt++;
			if (due_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status=%0d wait=%0d", status, wait_time_ms);
			end else begin
				v = due_verdicts.pop_front();
				if (status !== v.st || wait_time_ms !== v.wt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected status=%0d wait=%0d, got status=%0d wait=%0d",
							got_cnt, v.st, v.wt, status, wait_time_ms);
				end
			end
		end
		// Hold off once for a long stretch so the block backs up onto its input.
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!hold_done && got_cnt >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < idle_pct);
		end
	end

	// Watchdog: abandon the run when no word moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cnt <= 0;
		end else if (arst_n) begin
			quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Wait until nothing is queued, offered or owed; sample on the falling edge to stay clear
	// of the driver and monitor.
	task automatic quiesce();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || due_verdicts.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	// Write the budget register while the block is idle and mirror it in the predictor.
	task automatic write_budget(input bit [swa_pkg::COST_W-1:0] v);
		quiesce();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		budget_mirror = v;
		@(negedge clk);
	endtask

	task automatic push_req(input logic [swa_pkg::TIME_W-1:0] t,
			input logic [swa_pkg::COST_W-1:0] c);
		req_t r;
		r.t = t;
		r.c = c;
		pending_reqs.push_back(r);
	endtask

	// Mostly a rising clock of requests sized to contend for the budget, with some backwards
	// steps, long jumps, zero or oversized costs and fully random words mixed in.
	task automatic queue_traffic(input int unsigned n);
		logic [swa_pkg::COST_W-1:0] c;
		int unsigned       pick, cap;
		cap = (budget_mirror > 3) ? budget_mirror / 3 : budget_mirror;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			c = $urandom_range(1, cap);
			if (pick < 75) begin
				t_cursor = t_cursor + $urandom_range(0, 2500);
			end else if (pick < 80) begin
				t_cursor = t_cursor - $urandom_range(1, 5000);
			end else if (pick < 85) begin
				t_cursor = t_cursor + $urandom_range(64000, 300000);
			end else if (pick < 90) begin
				c = '0;
			end else if (pick < 95) begin
				c = (budget_mirror == 32'hFFFF_FFFF) ? budget_mirror :
					$urandom_range(budget_mirror + 32'd1, 32'hFFFF_FFFF);
			end else begin
				t_cursor = {16'($urandom), $urandom};
				c = $urandom;
			end
			push_req(t_cursor, c);
		end
	endtask

	initial begin
		clear_ring();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Budget still zero after reset: every request is invalid.
		push_req('0, 32'd1);
		// Budgets above the window are invalid whatever the request.
		write_budget(32'hFFFF_FFFF);
		push_req('1, 32'hFFFF_FFFF);
		write_budget(swa_pkg::WINDOW_US + 1);
		push_req(48'd5, 32'd100);

		// One-microsecond budget: zero cost, oversized costs, first admit, retry across the
		// whole ring, a long jump and time running backwards.
		write_budget(32'd1);
		push_req(48'd1000, '0);
		push_req(48'd1000, 32'd2);
		push_req(48'd1000, 32'hFFFF_FFFF);
		push_req(48'd1000, 32'd1);
		push_req(48'd1500, 32'd1);
		push_req(48'd65000, 32'd1);
		push_req(48'd2000, 32'd1);

		// Mid budget: jump to the end of time, fill a slot, then wrap back to zero and walk
		// the retry wait down as the full bucket approaches expiry.
		write_budget(32'd10000);
		push_req('1, 32'd4000);
		push_req(48'hFFFF_FFFF_FFFF - 48'd500, 32'd4000);
		push_req('1, 32'd3000);
		push_req('0, 32'd10000);
		push_req(48'd999, 32'd1);
		push_req(48'd1000, 32'd5000);
		push_req(48'd63999, 32'd1);
		push_req(48'd64000, 32'd1);
		push_req(48'd67000, 32'd10000);

		// Full window budget, filled in one go.
		write_budget(swa_pkg::WINDOW_US);
		push_req(48'd100000, swa_pkg::WINDOW_US);
		push_req(48'd100001, 32'd1);
		write_budget('0);
		push_req(48'd200000, 32'd7);

		// Random traffic at a spread of budgets.
		write_budget(32'd20000);
		t_cursor = 48'($urandom_range(0, 100000));
		queue_traffic(95);
		write_budget(swa_pkg::WINDOW_US);
		queue_traffic(95);
		// Run one phase flat out on both sides.
		idle_pct = 0;
		write_budget($urandom_range(1000, swa_pkg::WINDOW_US));
		queue_traffic(90);
		quiesce();
		idle_pct = 32;
		write_budget(32'd1);
		queue_traffic(60);
		write_budget($urandom_range(2, 500));
		queue_traffic(90);

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_verdicts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sliding_window_airtime_admission.f */
src/swa_pkg.sv
src/swa_div.sv
src/swa_dp.sv
src/swa_ctrl.sv
src/sliding_window_airtime_admission.sv
tb/tb.sv
